[sv/u8u16_pkg.sv]
package u8u16_pkg;

   // Width of the internal code point and code unit counters
   localparam int COUNT_BITS = 32;

   localparam logic [15:0] REPL_RESET   = 16'h003F;
   localparam logic [15:0] HI_SURR_BASE = 16'hD800;
   localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
   localparam logic [20:0] CP_MAX       = 21'h10FFFF;
   localparam logic [20:0] CP_PLANE1    = 21'h010000;
   localparam logic [7:0]  CONT_LOW     = 8'h80;
   localparam logic [7:0]  LEAD2_LOW    = 8'hC0;
   localparam logic [7:0]  LEAD3_LOW    = 8'hE0;
   localparam logic [7:0]  LEAD4_LOW    = 8'hF0;
   localparam logic [7:0]  LEAD5_LOW    = 8'hF8;
   localparam logic [7:0]  LEAD6_LOW    = 8'hFC;
   localparam logic [7:0]  LEAD7_LOW    = 8'hFE;
   localparam logic [7:0]  BAD_LEAD     = 8'hFF;

   typedef logic [COUNT_BITS-1:0] count_type;

   // One result item as it waits in the output queue
   typedef struct packed {
      logic [15:0] out_unit;
      logic        end_mark;
      logic        bad_sequence;
      logic [31:0] point_count;
      logic [31:0] unit_count;
   } result_type;

   // Saturating increment of a counter
   function automatic count_type sat_inc(input count_type v);
      sat_inc = (v == '1) ? v : v + count_type'(1);
   endfunction

endpackage

[sv/utf8_to_utf16_transcoder.sv]
// Each result item is queued behind waiting items and offered on rsp_valid when at the head.
// Throughput: one byte per cycle while rsp_ready is high; a byte that yields two items
// (surrogate pair, or terminator flushing an open sequence) drops req_ready until a pop.
// A three-entry output queue decouples the two channels, so a stalled rsp side stops input.
// Reset (synchronous, active high) clears the sequence state, the counts and the queue,
// and sets the replacement unit to '?'.
module utf8_to_utf16_transcoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_out_unit,
   output logic        rsp_end_mark,
   output logic        rsp_bad_sequence,
   output logic [31:0] rsp_point_count,
   output logic [31:0] rsp_unit_count,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import u8u16_pkg::*;

   logic [15:0] repl_ff;
   logic [2:0]  left_ff, left_in;
   logic [20:0] acc_ff, acc_in;
   logic        inv_ff, inv_in;
   count_type   points_ff, points_in;
   count_type   units_ff, units_in;

   result_type  q_ff [3];
   result_type  q_in [3];
   logic [1:0]  cnt_ff, cnt_in;

   logic        accept, pop;
   logic [7:0]  b;
   logic        do_pt, pt_bad, term;
   logic [20:0] pt_cp;
   logic        is_cont;
   logic [20:0] acc_next;
   logic        inv_next;
   logic [20:0] cp_off;
   count_type   p1, u1, u2;
   result_type  r0, r1;
   logic [1:0]  n_res;
   logic [1:0]  base;

   assign b         = req_in_byte;
   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (cnt_ff <= 2'd1);
   assign rsp_valid = (cnt_ff != 2'd0);

   assign rsp_out_unit     = q_ff[0].out_unit;
   assign rsp_end_mark     = q_ff[0].end_mark;
   assign rsp_bad_sequence = q_ff[0].bad_sequence;
   assign rsp_point_count  = q_ff[0].point_count;
   assign rsp_unit_count   = q_ff[0].unit_count;

   assign is_cont  = (b[7:6] == 2'b10);
   assign acc_next = is_cont ? {acc_ff[14:0], b[5:0]} : acc_ff;
   assign inv_next = inv_ff || !is_cont;

   // Decode the byte against the open sequence
   always_comb begin
      do_pt   = 1'b0;
      pt_bad  = 1'b0;
      pt_cp   = '0;
      term    = 1'b0;
      left_in = left_ff;
      acc_in  = acc_ff;
      inv_in  = inv_ff;
      if (b == 8'h00) begin
         term    = 1'b1;
         do_pt   = (left_ff != 3'd0);
         pt_bad  = 1'b1;
         left_in = '0;
         acc_in  = '0;
         inv_in  = 1'b0;
      end else if (left_ff == 3'd0) begin
         if (b < CONT_LOW) begin
            do_pt = 1'b1;
            pt_cp = {13'd0, b};
         end else if (b < LEAD2_LOW || b == BAD_LEAD) begin
            do_pt  = 1'b1;
            pt_bad = 1'b1;
         end else if (b < LEAD3_LOW) begin
            left_in = 3'd1;
            acc_in  = {16'd0, b[4:0]};
            inv_in  = 1'b0;
         end else if (b < LEAD4_LOW) begin
            left_in = 3'd2;
            acc_in  = {17'd0, b[3:0]};
            inv_in  = 1'b0;
         end else if (b < LEAD5_LOW) begin
            left_in = 3'd3;
            acc_in  = {18'd0, b[2:0]};
            inv_in  = 1'b0;
         end else begin
            left_in = (b < LEAD6_LOW) ? 3'd4 : (b < LEAD7_LOW) ? 3'd5 : 3'd6;
            acc_in  = '0;
            inv_in  = 1'b1;
         end
      end else begin
         left_in = left_ff - 3'd1;
         acc_in  = acc_next;
         inv_in  = inv_next;
         if (left_ff == 3'd1) begin
            do_pt   = 1'b1;
            pt_cp   = acc_next;
            pt_bad  = inv_next;
            acc_in  = '0;
            inv_in  = 1'b0;
         end
      end
   end

   assign p1     = do_pt ? sat_inc(points_ff) : points_ff;
   assign u1     = sat_inc(units_ff);
   assign u2     = sat_inc(u1);
   assign cp_off = pt_cp - CP_PLANE1;

   // Build up to two result items
   always_comb begin
      r0 = '0;
      r1 = '0;
      r0.point_count = 32'(p1);
      r1.point_count = 32'(p1);
      r0.unit_count  = 32'(u1);
      r1.unit_count  = 32'(u2);
      n_res = 2'd0;
      if (do_pt) begin
         if (pt_bad || pt_cp > CP_MAX) begin
            r0.out_unit     = repl_ff;
            r0.bad_sequence = 1'b1;
            n_res           = 2'd1;
         end else if (pt_cp[20:16] == 5'd0) begin
            r0.out_unit = pt_cp[15:0];
            n_res       = 2'd1;
         end else begin
            r0.out_unit = HI_SURR_BASE | {6'd0, cp_off[19:10]};
            r1.out_unit = LO_SURR_BASE | {6'd0, cp_off[9:0]};
            n_res       = 2'd2;
         end
      end
      // Append the terminator after any flushed sequence
      if (term) begin
         if (do_pt) begin
            r1.out_unit     = '0;
            r1.end_mark     = 1'b1;
            r1.bad_sequence = 1'b0;
            n_res           = 2'd2;
         end else begin
            r0.out_unit = '0;
            r0.end_mark = 1'b1;
            n_res       = 2'd1;
         end
      end
   end

   // Counter next values; clear both at the end of a string
   always_comb begin
      points_in = p1;
      case (n_res)
         2'd0:    units_in = units_ff;
         2'd1:    units_in = u1;
         default: units_in = u2;
      endcase
      if (term) begin
         points_in = '0;
         units_in  = '0;
      end
   end

   // Output queue: shift out on pop, append new items behind what remains
   always_comb begin
      base    = cnt_ff - {1'b0, pop};
      q_in[0] = pop ? q_ff[1] : q_ff[0];
      q_in[1] = pop ? q_ff[2] : q_ff[1];
      q_in[2] = q_ff[2];
      for (int i = 0; i < 3; i++) begin
         if (accept && n_res != 2'd0 && base == 2'(i)) q_in[i] = r0;
         if (accept && n_res == 2'd2 && base + 2'd1 == 2'(i)) q_in[i] = r1;
      end
      cnt_in = base + (accept ? n_res : 2'd0);
   end

   // Control and sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff   <= REPL_RESET;
         left_ff   <= '0;
         acc_ff    <= '0;
         inv_ff    <= 1'b0;
         points_ff <= '0;
         units_ff  <= '0;
         cnt_ff    <= '0;
      end else begin
         if (csr_wr_en) repl_ff <= csr_wr_data;
         if (accept) begin
            left_ff   <= left_in;
            acc_ff    <= acc_in;
            inv_ff    <= inv_in;
            points_ff <= points_in;
            units_ff  <= units_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   // Queue payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) q_ff[i] <= q_in[i];
   end

endmodule

[sv/u8u16_checker.sv]
module u8u16_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_out_unit,
   input logic        rsp_end_mark,
   input logic        rsp_bad_sequence,
   input logic [31:0] rsp_unit_count
);

   // Queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // Terminator carries a zero unit and no error
   a_term_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_mark) |-> (rsp_out_unit == 16'h0000 && !rsp_bad_sequence))
      else $error("terminator item malformed");

   // Every item counts itself
   a_units_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_unit_count != 32'd0))
      else $error("unit count zero on a result item");

   // Stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_unit)
                                     && $stable(rsp_unit_count)))
      else $error("stalled result item changed");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_unit     (rsp_out_unit),
   .rsp_end_mark     (rsp_end_mark),
   .rsp_bad_sequence (rsp_bad_sequence),
   .rsp_unit_count   (rsp_unit_count)
);
